FILE: hdl/cimap_pkg.sv
`default_nettype none

package cimap_pkg;

  // Register indexes on the configuration port
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;
  localparam logic [CFG_IDX_W-1:0] REG_INPUT_MODE    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TOGGLE_ENABLE = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_STORE_ENABLE  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_STEP_SIZE     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_TOP_LEVEL     = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_BOTTOM_LEVEL  = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_INITIAL_LEVEL = 3'd6;

  // Input modes; codes 5..7 are inert
  localparam logic [2:0] MODE_ANALOG = 3'd0;
  localparam logic [2:0] MODE_BUTTON = 3'd1;
  localparam logic [2:0] MODE_SWITCH = 3'd2;
  localparam logic [2:0] MODE_TICKER = 3'd3;
  localparam logic [2:0] MODE_ROTARY = 3'd4;

  localparam logic [1:0] BUZZ_NONE   = 2'd0;
  localparam logic [1:0] BUZZ_LIMIT  = 2'd1;
  localparam logic [1:0] BUZZ_CENTER = 2'd2;
  localparam logic [1:0] BUZZ_TICK   = 2'd3;

  // Reset values
  localparam logic [2:0]         RST_MODE   = MODE_BUTTON;
  localparam logic [14:0]        RST_STEP   = 15'd327;
  localparam logic signed [15:0] RST_TOP    = 16'sh7FFF;
  localparam logic signed [15:0] RST_BOTTOM = 16'sh8000;
  localparam logic signed [15:0] RST_LEVEL  = 16'sh8000;

  // Remainder unit: one quotient bit per cycle over the 16-bit magnitude
  localparam int DIV_STEPS = 16;
  localparam int DIV_CNT_W = $clog2(DIV_STEPS);

  typedef struct packed {
    logic               level_a;
    logic               level_b;
    logic signed [15:0] analog_sample;
    logic signed [3:0]  rotary_steps;
  } in_t;

  typedef struct packed {
    logic signed [15:0] control_value;
    logic [1:0]         buzz_pattern;
    logic               save_request;
  } out_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EVAL,
    S_DIV,
    S_FIX,
    S_DONE
  } state_t;

  typedef struct packed {
    logic accept;
    logic eval;
    logic div_step;
    logic fix;
    logic commit;
  } cmd_t;

  typedef struct packed {
    logic need_div;
    logic out_free;
  } sts_t;

endpackage

`default_nettype wire

FILE: hdl/cimap_ctrl.sv
`default_nettype none

module cimap_ctrl (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            in_valid,
  output logic                 in_stall,
  input  wire cimap_pkg::sts_t sts,
  output cimap_pkg::cmd_t      cmd
);

  localparam logic [cimap_pkg::DIV_CNT_W-1:0] CntLast =
    cimap_pkg::DIV_CNT_W'(cimap_pkg::DIV_STEPS - 1);

  cimap_pkg::state_t state_r, state_nxt;
  logic [cimap_pkg::DIV_CNT_W-1:0] cnt_r, cnt_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= cimap_pkg::S_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      cimap_pkg::S_IDLE: if (in_valid) state_nxt = cimap_pkg::S_EVAL;
      cimap_pkg::S_EVAL: begin
        state_nxt = sts.need_div ? cimap_pkg::S_DIV : cimap_pkg::S_FIX;
      end
      cimap_pkg::S_DIV:  if (cnt_r == CntLast) state_nxt = cimap_pkg::S_FIX;
      cimap_pkg::S_FIX:  state_nxt = cimap_pkg::S_DONE;
      cimap_pkg::S_DONE: if (sts.out_free) state_nxt = cimap_pkg::S_IDLE;
      default:           state_nxt = cimap_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_stall = 1'b1;
    cnt_nxt  = cnt_r;
    unique case (state_r)
      cimap_pkg::S_IDLE: begin
        in_stall   = 1'b0;
        cmd.accept = in_valid;
      end
      cimap_pkg::S_EVAL: begin
        cmd.eval = 1'b1;
        cnt_nxt  = '0;
      end
      cimap_pkg::S_DIV: begin
        cmd.div_step = 1'b1;
        cnt_nxt      = cnt_r + 1'b1;
      end
      cimap_pkg::S_FIX:  cmd.fix = 1'b1;
      cimap_pkg::S_DONE: cmd.commit = sts.out_free;
      default: ;
    endcase
  end

  a_div_len: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == cimap_pkg::S_DIV && cnt_r == CntLast) |=> state_r == cimap_pkg::S_FIX)
    else $error("remainder unit ran past its last step");

  a_accept_eval: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.accept |=> cmd.eval)
    else $error("accepted item not evaluated");

  a_done_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == cimap_pkg::S_DONE && !sts.out_free) |=> state_r == cimap_pkg::S_DONE)
    else $error("result dropped while output register busy");

endmodule

`default_nettype wire

FILE: hdl/cimap_dp.sv
`default_nettype none

module cimap_dp (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire cimap_pkg::in_t                   in_data,
  input  wire cimap_pkg::cmd_t                  cmd,
  output cimap_pkg::sts_t                       sts,
  input  wire logic                             cfg_valid,
  input  wire logic [cimap_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [cimap_pkg::CFG_DATA_W-1:0] cfg_data,
  output cimap_pkg::out_t                       out_data,
  output logic                                  out_valid,
  input  wire logic                             out_stall
);

  // Configuration
  logic [2:0]         mode_r;
  logic               toggle_r;
  logic               store_r;
  logic [14:0]        step_size_r;
  logic signed [15:0] top_r;
  logic signed [15:0] bot_r;

  // Block state
  logic signed [15:0] cur_r;
  logic               prev_a_r, prev_b_r;
  logic               prev_a_nxt, prev_b_nxt;

  // Work registers
  cimap_pkg::in_t     item_r;
  logic signed [19:0] val_r;
  logic signed [16:0] stp_r;
  logic               active_r, clamp_r, save_r;
  logic [1:0]         buzz_r;
  logic [14:0]        rem_r;
  logic [15:0]        quo_r;

  cimap_pkg::out_t    out_r;
  logic               out_valid_r;

  // Config writes; initial_level only matters at reset, so writes to it are dropped
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r      <= cimap_pkg::RST_MODE;
      toggle_r    <= 1'b0;
      store_r     <= 1'b0;
      step_size_r <= cimap_pkg::RST_STEP;
      top_r       <= cimap_pkg::RST_TOP;
      bot_r       <= cimap_pkg::RST_BOTTOM;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        cimap_pkg::REG_INPUT_MODE:    mode_r      <= cfg_data[2:0];
        cimap_pkg::REG_TOGGLE_ENABLE: toggle_r    <= cfg_data[0];
        cimap_pkg::REG_STORE_ENABLE:  store_r     <= cfg_data[0];
        cimap_pkg::REG_STEP_SIZE:     step_size_r <= cfg_data[14:0];
        cimap_pkg::REG_TOP_LEVEL:     top_r       <= cfg_data;
        cimap_pkg::REG_BOTTOM_LEVEL:  bot_r       <= cfg_data;
        default: ;
      endcase
    end
  end

  // Evaluate
  logic               a_rise, b_rise, flip, ev_active, ev_clamp, ev_save;
  logic signed [16:0] s17, tick_step, ev_step, sum17;
  logic signed [15:0] s16, ev_lo, ev_hi;
  logic signed [19:0] cur20, rot_prod, ev_nv, ev_val, ev_abs;
  logic [1:0]         ev_buzz;

  assign s16    = {1'b0, step_size_r};
  assign s17    = {2'b0, step_size_r};
  assign cur20  = 20'(cur_r);
  assign a_rise = item_r.level_a & ~prev_a_r;
  assign b_rise = item_r.level_b & ~prev_b_r;
  assign flip   = !(bot_r < top_r);
  assign sum17  = 17'(bot_r) + 17'(top_r);
  assign rot_prod = 20'(item_r.rotary_steps) * 20'(s16);

  always_comb begin
    tick_step  = '0;
    if (a_rise) tick_step = s17;
    if (b_rise) tick_step = -s17;

    ev_val     = cur20;
    ev_nv      = cur20;
    ev_step    = '0;
    ev_lo      = bot_r;
    ev_hi      = top_r;
    ev_active  = 1'b0;
    ev_save    = 1'b0;
    prev_a_nxt = prev_a_r;
    prev_b_nxt = prev_b_r;

    case (mode_r)
      cimap_pkg::MODE_ANALOG: ev_val = 20'(item_r.analog_sample);
      cimap_pkg::MODE_BUTTON: begin
        if (!toggle_r) begin
          ev_val = item_r.level_a ? 20'(top_r) : 20'(bot_r);
        end else begin
          if (a_rise) begin
            ev_val  = (cur_r == top_r) ? 20'(bot_r) : 20'(top_r);
            ev_save = store_r;
          end
          prev_a_nxt = item_r.level_a;
        end
      end
      cimap_pkg::MODE_SWITCH: begin
        if (item_r.level_a)      ev_val = 20'(top_r);
        else if (item_r.level_b) ev_val = 20'(bot_r);
        else                     ev_val = 20'(sum17[16:1]);
      end
      cimap_pkg::MODE_TICKER: begin
        ev_active  = a_rise | b_rise;
        ev_lo      = flip ? top_r : bot_r;
        ev_hi      = flip ? bot_r : top_r;
        ev_step    = flip ? -tick_step : tick_step;
        ev_nv      = cur20 + 20'(ev_step);
        prev_a_nxt = item_r.level_a;
        prev_b_nxt = item_r.level_b;
      end
      cimap_pkg::MODE_ROTARY: begin
        ev_active = (item_r.rotary_steps != '0);
        ev_step   = item_r.rotary_steps[3] ? -s17 : s17;
        ev_nv     = cur20 + rot_prod;
      end
      default: ;
    endcase

    // Clamp, lower limit (ev_lo) tested first
    ev_clamp = 1'b0;
    ev_buzz  = cimap_pkg::BUZZ_NONE;
    if (ev_active) begin
      ev_val = ev_nv;
      if (ev_nv < 20'(ev_lo)) begin
        ev_val   = 20'(ev_lo);
        ev_clamp = 1'b1;
        ev_buzz  = cimap_pkg::BUZZ_LIMIT;
      end else if (ev_nv > 20'(ev_hi)) begin
        ev_val   = 20'(ev_hi);
        ev_clamp = 1'b1;
        ev_buzz  = cimap_pkg::BUZZ_LIMIT;
      end
    end
    ev_abs = ev_val[19] ? -ev_val : ev_val;
  end

  assign sts.need_div = ev_active && !ev_clamp && (step_size_r != '0);
  assign sts.out_free = !out_valid_r || !out_stall;

  // Remainder step: restoring, one bit per cycle
  logic [15:0] dv_sh, dv_diff;
  logic        dv_ge;
  assign dv_sh   = {rem_r, quo_r[15]};
  assign dv_ge   = (dv_sh >= 16'(step_size_r));
  assign dv_diff = dv_sh - 16'(step_size_r);

  // Alignment: v - (step + r), r carries the sign of v
  logic signed [16:0] fx_r;
  logic signed [19:0] fx_val, fx_res;
  assign fx_r   = val_r[19] ? -17'({2'b0, rem_r}) : 17'({2'b0, rem_r});
  assign fx_val = val_r - 20'(stp_r) - 20'(fx_r);
  assign fx_res = (rem_r != '0) ? fx_val : val_r;

  always_ff @(posedge clk) begin
    if (cmd.accept) item_r <= in_data;
    if (cmd.eval) begin
      val_r    <= ev_val;
      stp_r    <= ev_step;
      active_r <= ev_active;
      clamp_r  <= ev_clamp;
      save_r   <= ev_save;
      buzz_r   <= ev_buzz;
      rem_r    <= '0;
      quo_r    <= ev_abs[15:0];
    end
    if (cmd.div_step) begin
      rem_r <= dv_ge ? dv_diff[14:0] : dv_sh[14:0];
      quo_r <= {quo_r[14:0], dv_ge};
    end
    if (cmd.fix && active_r && !clamp_r) begin
      val_r  <= fx_res;
      buzz_r <= (fx_res == '0) ? cimap_pkg::BUZZ_CENTER : cimap_pkg::BUZZ_TICK;
    end
    if (cmd.commit) begin
      out_r.control_value <= val_r[15:0];
      out_r.buzz_pattern  <= buzz_r;
      out_r.save_request  <= active_r ? (store_r && (val_r != cur20)) : save_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_r       <= cimap_pkg::RST_LEVEL;
      prev_a_r    <= 1'b0;
      prev_b_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.eval) begin
        prev_a_r <= prev_a_nxt;
        prev_b_r <= prev_b_nxt;
      end
      if (cmd.commit) cur_r <= val_r[15:0];
      if (cmd.commit)      out_valid_r <= 1'b1;
      else if (!out_stall) out_valid_r <= 1'b0;
    end
  end

  assign out_data  = out_r;
  assign out_valid = out_valid_r;

  a_commit_cur: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.commit |=> out_valid_r && (out_r.control_value == cur_r))
    else $error("output value and held level disagree");

  a_div_active: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.div_step |-> (active_r && !clamp_r && step_size_r != '0))
    else $error("remainder run for an item that needs no alignment");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_stall) |=> (out_valid_r && $stable(out_r)))
    else $error("stalled result changed or dropped");

endmodule

`default_nettype wire

FILE: hdl/control_input_value_mapper.sv
// Control input value mapper.
// Input channel in_valid/in_stall/in_data: one transfer per sample tick with
// both pin levels, the calibrated analog sample and the rotary detent count.
// Result channel out_valid/out_stall/out_data: one transfer per input with
// the new control value, the buzz code and the save request.
// Configuration: cfg_valid/cfg_ready/cfg_index/cfg_data; cfg_ready is always
// high, so a write lands on any cycle with cfg_valid. Write only while idle.
// Sequence: one item at a time. An item is evaluated the cycle after its
// transfer, then aligned (with a restoring remainder pass when a ticker
// or rotary step lands inside the limits with a nonzero step size), then
// committed; the next input is taken in the cycle after the commit.
// The remainder unit is the long path through the sequence.
// A finished result sits in the output register; the next input can already
// be worked on, but its commit waits while out_stall holds the old one.
// Reset (rst_n low, synchronous) restores register defaults, loads the
// current level with -32768 and clears edge history and the output valid.
`default_nettype none

module control_input_value_mapper (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             in_valid,
  output logic                                  in_stall,
  input  wire cimap_pkg::in_t                   in_data,
  output logic                                  out_valid,
  input  wire logic                             out_stall,
  output cimap_pkg::out_t                       out_data,
  input  wire logic                             cfg_valid,
  output logic                                  cfg_ready,
  input  wire logic [cimap_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [cimap_pkg::CFG_DATA_W-1:0] cfg_data
);

  cimap_pkg::cmd_t cmd;
  cimap_pkg::sts_t sts;

  // Register file never stalls a write
  assign cfg_ready = 1'b1;

  // Sequencer: accept, evaluate, remainder pass, align, commit
  cimap_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  // Config registers, level state, mode logic, remainder unit, output register
  cimap_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cmd       (cmd),
    .sts       (sts),
    .cfg_valid (cfg_valid & cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .out_data  (out_data),
    .out_valid (out_valid),
    .out_stall (out_stall)
  );

endmodule

`default_nettype wire
